/* sv/button_mode_led_pattern_controller_assert.svh */
// assertion macros for the led pattern controller
`ifndef BUTTON_MODE_LED_PATTERN_CONTROLLER_ASSERT_SVH
`define BUTTON_MODE_LED_PATTERN_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define BMLPC_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("bmlpc assertion failed");

// next-cycle implication
`define BMLPC_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("bmlpc assertion failed");

`endif

/* sv/bmlpc_pkg.sv */
`timescale 1ns / 1ps

package bmlpc_pkg;

   localparam int POT_W     = 10;
   localparam int CFG_W     = 10;
   localparam int LED_W     = 3;
   localparam int STABLE_W  = 11;
   localparam int PATTERN_W = 14;
   localparam int LIM_W     = 13;
   localparam int STEPS     = 6;

   localparam logic [STABLE_W-1:0]  STABLE_MAX     = '1;
   localparam logic [PATTERN_W-1:0] PATTERN_MAX    = '1;
   localparam logic [CFG_W-1:0]     DEBOUNCE_RESET = 10'd50;
   localparam logic [CFG_W-1:0]     CHASE_RESET    = 10'd100;
   localparam logic [LED_W-1:0]     LED_NONE       = 3'b000;
   localparam logic [LED_W-1:0]     LED_ALL        = 3'b111;

   typedef enum logic [1:0] {
      MODE_OFF   = 2'd0,
      MODE_ON    = 2'd1,
      MODE_BLINK = 2'd2,
      MODE_CHASE = 2'd3
   } mode_type;

   typedef enum logic [0:0] {
      CSR_DEBOUNCE = 1'b0,
      CSR_CHASE    = 1'b1
   } csr_index_type;

   typedef logic [STEPS-1:0][LIM_W-1:0] chase_lim_type;

   typedef struct packed {
      logic [CFG_W-1:0] debounce;
      chase_lim_type    chase_lim;
   } cfg_type;

   typedef struct packed {
      mode_type               mode;
      logic                   last_raw;
      logic                   stable_btn;
      logic [STABLE_W-1:0]    stable_cnt;
      logic [PATTERN_W-1:0]   pattern_cnt;
      logic [LED_W-1:0]       led;
   } state_type;

   // step k of the chase fires once the count passes (k+1) * step
   function automatic chase_lim_type chase_limits(input logic [CFG_W-1:0] step);
      logic [LIM_W-1:0] s1;
      logic [LIM_W-1:0] s2;
      logic [LIM_W-1:0] s4;
      chase_lim_type    lim;
      s1 = {{(LIM_W-CFG_W){1'b0}}, step};
      s2 = s1 << 1;
      s4 = s1 << 2;
      lim[0] = s1;
      lim[1] = s2;
      lim[2] = s1 + s2;
      lim[3] = s4;
      lim[4] = s1 + s4;
      lim[5] = s2 + s4;
      return lim;
   endfunction

   localparam state_type STATE_RESET = '{
      mode:        MODE_OFF,
      last_raw:    1'b1,
      stable_btn:  1'b0,
      stable_cnt:  '0,
      pattern_cnt: '0,
      led:         LED_NONE
   };

endpackage

/* sv/bmlpc_if.sv */
`timescale 1ns / 1ps

interface bmlpc_req_if;
   logic                          valid;
   logic                          ready;
   logic                          button_level;
   logic [bmlpc_pkg::POT_W-1:0]   pot_sample;

   modport source (output valid, output button_level, output pot_sample, input ready);
   modport sink   (input valid, input button_level, input pot_sample, output ready);
endinterface

interface bmlpc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bmlpc_pkg::LED_W-1:0]   led_bits;
   logic [1:0]                    current_mode;

   modport source (output valid, output led_bits, output current_mode, input ready);
   modport sink   (input valid, input led_bits, input current_mode, output ready);
endinterface

/* sv/bmlpc_tick.sv */
`timescale 1ns / 1ps

module bmlpc_tick (
   input  bmlpc_pkg::state_type                cur,
   input  bmlpc_pkg::cfg_type                  cfg,
   input  logic                                button_level,
   input  logic [bmlpc_pkg::POT_W-1:0]         pot_sample,
   output bmlpc_pkg::state_type                nxt
);
   import bmlpc_pkg::*;

   logic [PATTERN_W-1:0] pc_inc;

   assign pc_inc = (cur.pattern_cnt == PATTERN_MAX) ? cur.pattern_cnt
                                                    : cur.pattern_cnt + 14'd1;

   always_comb begin
      nxt = cur;

      // debounce
      if (button_level != cur.last_raw) begin
         nxt.stable_cnt = '0;
      end else if (cur.stable_cnt != STABLE_MAX) begin
         nxt.stable_cnt = cur.stable_cnt + 11'd1;
      end
      if (nxt.stable_cnt > {1'b0, cfg.debounce} && button_level != cur.stable_btn) begin
         nxt.stable_btn = button_level;
         if (button_level) begin
            nxt.mode = mode_type'(cur.mode + 2'd1);
         end
      end
      nxt.last_raw = button_level;

      // led pattern
      unique case (nxt.mode)
         MODE_OFF: begin
            nxt.led = LED_NONE;
         end
         MODE_ON: begin
            nxt.led = LED_ALL;
         end
         MODE_BLINK: begin
            nxt.pattern_cnt = (cur.mode != MODE_BLINK) ? '0 : pc_inc;
            if (nxt.pattern_cnt > {4'b0, pot_sample}) begin
               nxt.led         = ~cur.led;
               nxt.pattern_cnt = '0;
            end
         end
         MODE_CHASE: begin
            if (cur.mode != MODE_CHASE) begin
               nxt.pattern_cnt = '0;
               nxt.led         = LED_NONE;
            end else begin
               nxt.pattern_cnt = pc_inc;
            end
            if (nxt.pattern_cnt > {1'b0, cfg.chase_lim[0]}) begin
               nxt.led[0] = 1'b1;
            end
            if (nxt.pattern_cnt > {1'b0, cfg.chase_lim[1]}) begin
               nxt.led[0] = 1'b0;
               nxt.led[1] = 1'b1;
            end
            if (nxt.pattern_cnt > {1'b0, cfg.chase_lim[2]}) begin
               nxt.led[1] = 1'b0;
               nxt.led[2] = 1'b1;
            end
            if (nxt.pattern_cnt > {1'b0, cfg.chase_lim[3]}) begin
               nxt.led[2] = 1'b0;
               nxt.led[1] = 1'b1;
            end
            if (nxt.pattern_cnt > {1'b0, cfg.chase_lim[4]}) begin
               nxt.led[1] = 1'b0;
               nxt.led[0] = 1'b1;
            end
            if (nxt.pattern_cnt > {1'b0, cfg.chase_lim[5]}) begin
               nxt.led[0]      = 1'b0;
               nxt.pattern_cnt = '0;
            end
         end
      endcase
   end

endmodule

/* sv/button_mode_led_pattern_controller.sv */
`timescale 1ns / 1ps

// channel   role     payload
// req_ch    sink     button_level, pot_sample (one tick per transfer)
// rsp_ch    source   led_bits, current_mode (one per request, after the tick)
// csr_*     write    index 0 debounce_ticks, index 1 chase_step_ticks
//
// two stages: an input register, then the tick update into the state register,
// whose led and mode fields drive the response payload
// one request per cycle sustained while rsp_ch.ready is high
// requests keep flowing while a response waits, until both stages are full
// reset is synchronous and restores the state and register reset values
// chase step multiples are formed when chase_step_ticks is written

module button_mode_led_pattern_controller (
   input  logic                          clock,
   input  logic                          reset,
   bmlpc_req_if.sink                     req_ch,
   bmlpc_rsp_if.source                   rsp_ch,
   input  logic                          csr_we,
   input  bmlpc_pkg::csr_index_type      csr_index,
   input  logic [bmlpc_pkg::CFG_W-1:0]   csr_wdata
);
   import bmlpc_pkg::*;

   `include "button_mode_led_pattern_controller_assert.svh"

   logic              in_valid_ff;
   logic              in_btn_ff;
   logic [POT_W-1:0]  in_pot_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   state_type         state_ff;
   state_type         state_in;
   cfg_type           cfg_ff;
   logic              tick_take;

   assign tick_take    = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || tick_take;
   assign rsp_valid_in = tick_take || (rsp_valid_ff && !rsp_ch.ready);

   bmlpc_tick u_tick (
      .cur          (state_ff),
      .cfg          (cfg_ff),
      .button_level (in_btn_ff),
      .pot_sample   (in_pot_ff),
      .nxt          (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_btn_ff <= req_ch.button_level;
         in_pot_ff <= req_ch.pot_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (tick_take) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce  <= DEBOUNCE_RESET;
         cfg_ff.chase_lim <= chase_limits(CHASE_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEBOUNCE: cfg_ff.debounce  <= csr_wdata;
            CSR_CHASE:    cfg_ff.chase_lim <= chase_limits(csr_wdata);
         endcase
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.led_bits     = state_ff.led;
   assign rsp_ch.current_mode = state_ff.mode;

   `BMLPC_ASSERT_NOW(a_off_dark, clock, reset,
      rsp_ch.valid && rsp_ch.current_mode == MODE_OFF, rsp_ch.led_bits == LED_NONE)
   `BMLPC_ASSERT_NOW(a_on_lit, clock, reset,
      rsp_ch.valid && rsp_ch.current_mode == MODE_ON, rsp_ch.led_bits == LED_ALL)
   `BMLPC_ASSERT_NOW(a_mode_step, clock, reset,
      !$past(reset) && state_ff.mode != $past(state_ff.mode),
      state_ff.mode == mode_type'($past(state_ff.mode) + 2'd1))
   `BMLPC_ASSERT_NEXT(a_state_hold, clock, reset,
      !tick_take, $stable(state_ff))

endmodule

/* bench/button_mode_led_pattern_controller_test.sv */
`timescale 1ns / 1ps

module button_mode_led_pattern_controller_test;
   import bmlpc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int HOLD_OFF_AFTER = 400;
   localparam int SCRIPT_ROWS = 25;

   typedef struct packed {
      logic [LED_W-1:0] led;
      mode_type         mode;
   } panel_type;

   typedef struct packed {
      logic             btn;
      logic [POT_W-1:0] pot;
      logic             typed;
      logic [LED_W-1:0] led;
      mode_type         mode;
   } tick_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   csr_index_type csr_index;
   logic [CFG_W-1:0] csr_wdata;

   bmlpc_req_if req_ch();
   bmlpc_rsp_if rsp_ch();

   button_mode_led_pattern_controller uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // mirror of the controller state and registers
   logic [CFG_W-1:0]     debounce_cfg = DEBOUNCE_RESET;
   logic [CFG_W-1:0]     chase_cfg = CHASE_RESET;
   mode_type             cur_mode = MODE_OFF;
   logic                 last_btn = 1'b1;
   logic                 held_btn = 1'b0;
   logic [STABLE_W-1:0]  settle_cnt = '0;
   logic [PATTERN_W-1:0] pattern_cnt = '0;
   logic [LED_W-1:0]     led_now = LED_NONE;

   panel_type pending_panels[$];
   panel_type want;
   int mismatches = 0;
   int panels_seen = 0;
   int cycle_count = 0;
   int burst_left = 0;
   logic btn_level_now = 1'b0;

   int unsigned phase_debounce [6] = '{1, 0, 4, 50, 2, 7};
   int unsigned phase_chase [6] = '{2, 1, 6, 100, 1023, 0};
   int unsigned phase_span [6] = '{200, 150, 200, 200, 150, 150};

   // debounce 0 and chase step 0 are written before this table runs
   tick_row_type script [SCRIPT_ROWS] = '{
      '{1'b0, 10'd0,    1'b1, LED_NONE, MODE_OFF},
      '{1'b1, 10'd1023, 1'b0, LED_NONE, MODE_OFF},
      '{1'b1, 10'd1023, 1'b1, LED_ALL,  MODE_ON},
      '{1'b0, 10'd0,    1'b0, LED_NONE, MODE_OFF},
      '{1'b0, 10'd0,    1'b0, LED_NONE, MODE_OFF},
      '{1'b1, 10'd0,    1'b0, LED_NONE, MODE_OFF},
      '{1'b1, 10'd1023, 1'b1, LED_ALL,  MODE_BLINK},
      '{1'b1, 10'd1023, 1'b0, LED_NONE, MODE_OFF},
      '{1'b1, 10'd0,    1'b1, LED_NONE, MODE_BLINK},
      '{1'b1, 10'd0,    1'b1, LED_ALL,  MODE_BLINK},
      '{1'b0, 10'd512,  1'b0, LED_NONE, MODE_OFF},
      '{1'b0, 10'd512,  1'b0, LED_NONE, MODE_OFF},
      '{1'b1, 10'd0,    1'b0, LED_NONE, MODE_OFF},
      '{1'b1, 10'd0,    1'b1, LED_NONE, MODE_CHASE},
      '{1'b1, 10'd0,    1'b1, LED_NONE, MODE_CHASE},
      '{1'b0, 10'd1023, 1'b0, LED_NONE, MODE_OFF},
      '{1'b0, 10'd1023, 1'b0, LED_NONE, MODE_OFF},
      '{1'b1, 10'd1023, 1'b0, LED_NONE, MODE_OFF},
      '{1'b1, 10'd1023, 1'b1, LED_NONE, MODE_OFF},
      '{1'b0, 10'd341,  1'b0, LED_NONE, MODE_OFF},
      '{1'b1, 10'd682,  1'b0, LED_NONE, MODE_OFF},
      '{1'b0, 10'd341,  1'b0, LED_NONE, MODE_OFF},
      '{1'b1, 10'd682,  1'b0, LED_NONE, MODE_OFF},
      '{1'b1, 10'd5,    1'b1, LED_NONE, MODE_OFF},
      '{1'b0, 10'd5,    1'b0, LED_NONE, MODE_OFF}
   };

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // one tick of the controller
   task automatic advance_tick(input logic btn, input logic [POT_W-1:0] pot,
                               output panel_type panel);
      mode_type prior;
      logic [1:0] next_mode;
      int e;
      int s;
      prior = cur_mode;
      if (btn != last_btn)
         settle_cnt = '0;
      else if (settle_cnt != STABLE_MAX)
         settle_cnt = settle_cnt + 1'b1;
      if (settle_cnt > debounce_cfg && btn != held_btn) begin
         held_btn = btn;
         if (btn) begin
            next_mode = cur_mode + 2'd1;
            cur_mode = mode_type'(next_mode);
         end
      end
      last_btn = btn;
      case (cur_mode)
         MODE_OFF: led_now = LED_NONE;
         MODE_ON: led_now = LED_ALL;
         MODE_BLINK: begin
            if (prior != MODE_BLINK)
               pattern_cnt = '0;
            else if (pattern_cnt != PATTERN_MAX)
               pattern_cnt = pattern_cnt + 1'b1;
            if (pattern_cnt > pot) begin
               led_now = ~led_now;
               pattern_cnt = '0;
            end
         end
         default: begin
            if (prior != MODE_CHASE) begin
               pattern_cnt = '0;
               led_now = LED_NONE;
            end else if (pattern_cnt != PATTERN_MAX) begin
               pattern_cnt = pattern_cnt + 1'b1;
            end
            e = int'(pattern_cnt);
            s = int'(chase_cfg);
            if (e > s) led_now[0] = 1'b1;
            if (e > 2 * s) begin
               led_now[0] = 1'b0;
               led_now[1] = 1'b1;
            end
            if (e > 3 * s) begin
               led_now[1] = 1'b0;
               led_now[2] = 1'b1;
            end
            if (e > 4 * s) begin
               led_now[2] = 1'b0;
               led_now[1] = 1'b1;
            end
            if (e > 5 * s) begin
               led_now[1] = 1'b0;
               led_now[0] = 1'b1;
            end
            if (e > 6 * s) begin
               led_now[0] = 1'b0;
               pattern_cnt = '0;
            end
         end
      endcase
      panel.led = led_now;
      panel.mode = cur_mode;
   endtask

   function automatic logic [POT_W-1:0] pick_pot();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return POT_W'($urandom_range(0, 1023));
         default: return POT_W'($urandom_range(0, 12));
      endcase
   endfunction

   // offer one tick, with sender gaps between bursts
   task automatic offer_tick(input logic btn, input logic [POT_W-1:0] pot,
                             input logic typed, input logic [LED_W-1:0] typed_led,
                             input mode_type typed_mode);
      int gap;
      panel_type panel;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 20);
      end
      burst_left--;
      req_ch.valid = 1'b1;
      req_ch.button_level = btn;
      req_ch.pot_sample = pot;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      advance_tick(btn, pot, panel);
      if (typed) begin
         panel.led = typed_led;
         panel.mode = typed_mode;
      end
      pending_panels.push_back(panel);
      @(negedge clock);
   endtask

   task automatic hold_button(input logic btn, input int unsigned ticks);
      repeat (ticks) offer_tick(btn, pick_pot(), 1'b0, LED_NONE, MODE_OFF);
      btn_level_now = btn;
   endtask

   // presses and releases long enough to pass the debouncer, with some bounces
   task automatic shake_button(input int unsigned span);
      int unsigned sent;
      int unsigned len;
      int unsigned bounce_max;
      sent = 0;
      while (sent < span) begin
         bounce_max = (debounce_cfg > 0) ? debounce_cfg + 1 : 1;
         if ($urandom_range(0, 4) == 0)
            len = $urandom_range(1, bounce_max);
         else
            len = debounce_cfg + 2 + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 120)
                                                                   : $urandom_range(0, 8));
         hold_button(~btn_level_now, len);
         sent += len;
      end
   endtask

   task automatic settle();
      req_ch.valid = 1'b0;
      while (pending_panels.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CFG_W-1:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_DEBOUNCE)
         debounce_cfg = val;
      else
         chase_cfg = val;
   endtask

   // receiver stall pattern, plus one long hold-off to back up the pipeline
   initial begin
      int style;
      int tick_no;
      bit held_off;
      style = 0;
      tick_no = 0;
      held_off = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_off && panels_seen >= HOLD_OFF_AFTER) begin
            rsp_ch.ready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            held_off = 1'b1;
         end
         if (tick_no % 48 == 0) style = $urandom_range(0, 3);
         tick_no++;
         case (style)
            0: rsp_ch.ready = 1'b1;
            1: rsp_ch.ready = 1'($urandom_range(0, 1));
            2: rsp_ch.ready = ($urandom_range(0, 3) == 0);
            default: rsp_ch.ready = (tick_no % 5 != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_panels.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected transfer, expected none, got led %0d mode %0d",
                     $time, rsp_ch.led_bits, rsp_ch.current_mode);
         end else begin
            want = pending_panels.pop_front();
            panels_seen++;
            if (rsp_ch.led_bits !== want.led) begin
               mismatches++;
               $display("%0t: led_bits expected %0d, got %0d",
                        $time, want.led, rsp_ch.led_bits);
            end
            if (rsp_ch.current_mode !== want.mode) begin
               mismatches++;
               $display("%0t: current_mode expected %0d, got %0d",
                        $time, want.mode, rsp_ch.current_mode);
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_DEBOUNCE;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.button_level = 1'b0;
      req_ch.pot_sample = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      write_csr(CSR_DEBOUNCE, 10'd0);
      write_csr(CSR_CHASE, 10'd0);
      for (int i = 0; i < SCRIPT_ROWS; i++)
         offer_tick(script[i].btn, script[i].pot, script[i].typed,
                    script[i].led, script[i].mode);
      btn_level_now = script[SCRIPT_ROWS-1].btn;

      for (int p = 0; p < 6; p++) begin
         settle();
         write_csr(CSR_DEBOUNCE, CFG_W'(phase_debounce[p]));
         write_csr(CSR_CHASE, CFG_W'(phase_chase[p]));
         shake_button(phase_span[p]);
      end

      // widest settings; a press shorter than the debounce window is ignored
      settle();
      write_csr(CSR_DEBOUNCE, 10'd1023);
      write_csr(CSR_CHASE, 10'd1023);
      hold_button(1'b0, 3);
      hold_button(1'b1, 60);
      hold_button(1'b0, 40);

      req_ch.valid = 1'b0;
      while (pending_panels.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
